// File: rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, register codes, reset values and micro-step codes for the
// hover thrust estimator.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int ThrustBits = 16;

  // configuration register indexes
  localparam logic [2:0] RegMinHover   = 3'd0;
  localparam logic [2:0] RegMaxHover   = 3'd1;
  localparam logic [2:0] RegInitHover  = 3'd2;
  localparam logic [2:0] RegInitVar    = 3'd3;
  localparam logic [2:0] RegProcNoise  = 3'd4;
  localparam logic [2:0] RegAccelNoise = 3'd5;
  localparam logic [2:0] RegGateSize   = 3'd6;
  localparam logic [2:0] RegGravity    = 3'd7;

  localparam logic [15:0] RstMinHover   = 16'd6554;
  localparam logic [15:0] RstMaxHover   = 16'd58982;
  localparam logic [15:0] RstInitHover  = 16'd32768;
  localparam logic [31:0] RstInitVar    = 32'd42949673;
  localparam logic [31:0] RstProcNoise  = 32'd55654;
  localparam logic [31:0] RstAccelNoise = 32'd327680;
  localparam logic [11:0] RstGateSize   = 12'd768;
  localparam logic [14:0] RstGravity    = 15'd10042;
  // initial hover clamped by the reset clamp limits
  localparam logic [15:0] RstHover      = 16'd32768;

  localparam logic [31:0] MicrosPerSec  = 32'd1000000;
  // floor(2^48 / 1e6); estimate is low by at most one
  localparam logic [28:0] RecipMicros   = 29'd281474976;

  // micro-step codes
  localparam logic [3:0] StPn   = 4'd0;   // process_noise * dt
  localparam logic [3:0] StPdiv = 4'd1;   // quotient estimate by reciprocal
  localparam logic [3:0] StPfix = 4'd2;   // estimate * 1e6, correct, grow variance
  localparam logic [3:0] StGt   = 4'd3;   // g * thrust
  localparam logic [3:0] StPred = 4'd4;   // gt / ht, innovation
  localparam logic [3:0] StHt2  = 4'd5;   // ht * ht
  localparam logic [3:0] StHq   = 4'd6;   // jacobian
  localparam logic [3:0] StHqp  = 4'd7;   // hq * p
  localparam logic [3:0] StHhp  = 4'd8;   // hq * x, S
  localparam logic [3:0] StAi2  = 4'd9;   // innov^2
  localparam logic [3:0] StGg   = 4'd10;  // gate^2
  localparam logic [3:0] StGgs  = 4'd11;  // gate^2 * S, gate test
  localparam logic [3:0] StXa   = 4'd12;  // x * |innov|
  localparam logic [3:0] StDm   = 4'd13;  // estimate change
  localparam logic [3:0] StF    = 4'd14;  // variance factor
  localparam logic [3:0] StPf   = 4'd15;  // variance shrink

  typedef struct packed {
    logic       load;
    logic       go;
    logic       commit;
    logic [3:0] step;
  } hte_cmd_t;

  typedef struct packed {
    logic restart;
    logic skip;
    logic do_update;
    logic mul_done;
    logic div_done;
  } hte_sts_t;

  function automatic logic step_is_div(input logic [3:0] st);
    return (st == StPred) || (st == StHq) || (st == StDm) || (st == StF);
  endfunction

  function automatic logic [15:0] clamp_hover(input logic signed [55:0] x,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] r;
    if (x < $signed({40'd0, lo})) r = lo;
    else if (x < $signed({40'd0, hi})) r = x[15:0];
    else r = hi;
    return r;
  endfunction

endpackage

// File: rtl/hover_thrust_kalman_estimator.sv
// ----------------------------------------------------------------------------
// hover_thrust_kalman_estimator
// One-state Kalman filter tracking the hover thrust from acceleration and
// thrust samples, in fixed point.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid_i/in_stall_o | req_type, dt_us, accel_z, thrust
//  out     | out_valid_o/out_stall_i | hover_estimate, hover_change, innovation,
//          |                      | gated, initialized
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An updating measurement runs twelve multiplies and four divisions (one
// quotient bit per cycle); a gated sample runs ten multiplies and two
// divisions. Restart and zero-dt samples go straight to commit.
// Reset loads the register defaults and the initial state at once.
// A new sample is taken while a result still waits; its commit holds off
// until the output transaction completes.
module hover_thrust_kalman_estimator
  import hte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [15:0]        dt_us_i,
  input  logic signed [17:0] accel_z_i,
  input  logic [15:0]        thrust_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        hover_estimate_o,
  output logic signed [16:0] hover_change_o,
  output logic signed [17:0] innovation_o,
  output logic               gated_o,
  output logic               initialized_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  hte_cmd_t cmd;
  hte_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hte_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .dt_us_i          (dt_us_i),
    .accel_z_i        (accel_z_i),
    .thrust_i         (thrust_i),
    .hover_estimate_o (hover_estimate_o),
    .hover_change_o   (hover_change_o),
    .innovation_o     (innovation_o),
    .gated_o          (gated_o),
    .initialized_o    (initialized_o)
  );

endmodule

// File: rtl/hte_mul.sv
// ----------------------------------------------------------------------------
// hte_mul
// Byte-serial multiplier: 48 x 32 bit operands, 64-bit product.
// ----------------------------------------------------------------------------
module hte_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [47:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, acc_q, part;
  logic [31:0] b_q;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  assign part = a_q * {56'd0, b_q[7:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= {16'd0, a_i};
      b_q   <= b_i;
      acc_q <= 64'd0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
      a_q   <= {a_q[55:0], 8'd0};
      b_q   <= {8'd0, b_q[31:8]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/hte_div.sv
// ----------------------------------------------------------------------------
// hte_div
// Restoring divider: 64-bit dividend, 48-bit divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module hte_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] num_i,
  input  logic [47:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] quo_q;
  logic [47:0] rem_q, den_q;
  logic [48:0] trial, diff;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= num_i;
      rem_q <= 48'd0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[48]) begin
        rem_q <= diff[47:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[47:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/hte_datapath.sv
// ----------------------------------------------------------------------------
// hte_datapath
// Configuration registers, filter state and the working registers of one
// update, around a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
module hte_datapath
  import hte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hte_cmd_t           cmd_i,
  output hte_sts_t           sts_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               req_type_i,
  input  logic [15:0]        dt_us_i,
  input  logic signed [17:0] accel_z_i,
  input  logic [15:0]        thrust_i,
  output logic [15:0]        hover_estimate_o,
  output logic signed [16:0] hover_change_o,
  output logic signed [17:0] innovation_o,
  output logic               gated_o,
  output logic               initialized_o
);

  // configuration
  logic [15:0] min_q, max_q, init_h_q;
  logic [31:0] init_v_q, pn_q, an_q;
  logic [11:0] gate_q;
  logic [14:0] grav_q;

  // filter state
  logic [15:0]        hover_q;
  logic [31:0]        var_q;
  logic signed [16:0] change_q;
  logic signed [17:0] innov_q;
  logic               gated_q, init_q;

  // captured sample and working values
  logic               req_q;
  logic [15:0]        dt_q, thr_q;
  logic signed [17:0] acc_q;
  logic [47:0] t_q;
  logic [28:0] q0_q;
  logic [31:0] p_q, hh_q;
  logic [30:0] gt_q;
  logic signed [17:0] w_innov_q;
  logic [17:0] absi_q;
  logic [19:0] hq_q;
  logic [35:0] x_q;
  logic [39:0] hhp_q, s_q;
  logic [34:0] ai2_q;
  logic [23:0] gg_q;
  logic        pass_q;
  logic [53:0] xa_q, dmag_q;
  logic [24:0] f_q;

  logic [15:0] ht;
  logic [14:0] g;
  logic [47:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] div_n, prod, quo;
  logic [47:0] div_d;
  logic        mul_done, div_done;

  assign ht = (hover_q == 16'd0) ? 16'd1 : hover_q;
  assign g  = (grav_q == 15'd0) ? 15'd1 : grav_q;

  always_comb begin
    mul_a = 48'd0;
    mul_b = 32'd0;
    div_n = 64'd0;
    div_d = 48'd1;
    case (cmd_i.step)
      StPn:   begin mul_a = {16'd0, pn_q};  mul_b = {16'd0, dt_q}; end
      StPdiv: begin mul_a = {19'd0, RecipMicros}; mul_b = t_q[47:16]; end
      StPfix: begin mul_a = {19'd0, q0_q};  mul_b = MicrosPerSec; end
      StGt:   begin mul_a = {33'd0, g};     mul_b = {16'd0, thr_q}; end
      StPred: begin div_n = {33'd0, gt_q};  div_d = {32'd0, ht}; end
      StHt2:  begin mul_a = {32'd0, ht};    mul_b = {16'd0, ht}; end
      StHq:   begin div_n = {17'd0, gt_q, 16'd0}; div_d = {16'd0, hh_q}; end
      StHqp:  begin mul_a = {16'd0, p_q};   mul_b = {12'd0, hq_q}; end
      StHhp:  begin mul_a = {12'd0, x_q};   mul_b = {12'd0, hq_q}; end
      StAi2:  begin mul_a = {30'd0, absi_q}; mul_b = {14'd0, absi_q}; end
      StGg:   begin mul_a = {36'd0, gate_q}; mul_b = {20'd0, gate_q}; end
      StGgs:  begin mul_a = {8'd0, s_q};    mul_b = {8'd0, gg_q}; end
      StXa:   begin mul_a = {12'd0, x_q};   mul_b = {14'd0, absi_q}; end
      StDm:   begin div_n = {10'd0, xa_q};  div_d = {8'd0, s_q}; end
      StF:    begin div_n = {hhp_q, 24'd0}; div_d = {8'd0, s_q}; end
      StPf:   begin mul_a = {16'd0, p_q};   mul_b = {7'd0, f_q}; end
      default: begin end
    endcase
  end

  hte_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go && !step_is_div(cmd_i.step)),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  hte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go && step_is_div(cmd_i.step)),
    .num_i  (div_n),
    .den_i  (div_d),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // step results
  logic [47:0]        p_rem;
  logic [28:0]        p_inc;
  logic [32:0]        p_sum;
  logic signed [34:0] innov_full;
  logic signed [17:0] innov_sat;
  logic [40:0]        s_sum;
  logic               res_done;

  // remainder of the low estimate; one compare fixes the quotient
  assign p_rem      = t_q - prod[47:0];
  assign p_inc      = q0_q + {28'd0, (p_rem >= {16'd0, MicrosPerSec})};
  assign p_sum      = {1'b0, var_q} + {4'd0, p_inc};
  assign innov_full = {{17{acc_q[17]}}, acc_q} - $signed({3'd0, quo[31:0]})
                      + $signed({20'd0, g});
  assign innov_sat  = (innov_full > 35'sd131071) ? 18'sd131071 :
                      (innov_full < -35'sd131072) ? -18'sd131072 : innov_full[17:0];
  assign s_sum      = {1'b0, prod[55:16]} + {5'd0, an_q, 4'd0};
  assign res_done   = step_is_div(cmd_i.step) ? div_done : mul_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      dt_q  <= dt_us_i;
      acc_q <= accel_z_i;
      thr_q <= thrust_i;
    end
    if (res_done) begin
      case (cmd_i.step)
        StPn:   t_q <= prod[47:0];
        StPdiv: q0_q <= prod[60:32];
        StPfix: p_q <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        StGt:   gt_q <= prod[30:0];
        StPred: begin
          w_innov_q <= innov_sat;
          absi_q    <= innov_sat[17] ? 18'(-innov_sat) : innov_sat;
        end
        StHt2:  hh_q <= prod[31:0];
        StHq:   hq_q <= (|quo[63:20]) ? 20'hF_FFFF : quo[19:0];
        StHqp:  x_q <= prod[51:16];
        StHhp: begin
          hhp_q <= prod[55:16];
          s_q   <= s_sum[40] ? 40'hFF_FFFF_FFFF : s_sum[39:0];
        end
        StAi2:  ai2_q <= prod[34:0];
        StGg:   gg_q <= prod[23:0];
        StGgs:  pass_q <= (s_q == 40'd0) || ({13'd0, ai2_q, 16'd0} < prod);
        StXa:   xa_q <= prod[53:0];
        StDm:   dmag_q <= quo[53:0];
        StF:    f_q <= quo[24:0];
        StPf:   p_q <= p_q - prod[55:24];
        default: begin end
      endcase
    end
  end

  // commit
  logic signed [55:0] prev_w, dm_w, h_raw;
  logic [15:0]        h_new;
  logic               upd;

  assign upd    = pass_q && (s_q != 40'd0);
  assign prev_w = $signed({40'd0, hover_q});
  assign dm_w   = $signed({2'd0, dmag_q});
  assign h_raw  = !upd ? prev_w : (w_innov_q > 18'sd0) ? prev_w - dm_w : prev_w + dm_w;
  assign h_new  = clamp_hover(h_raw, min_q, max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= RstMinHover;
      max_q    <= RstMaxHover;
      init_h_q <= RstInitHover;
      init_v_q <= RstInitVar;
      pn_q     <= RstProcNoise;
      an_q     <= RstAccelNoise;
      gate_q   <= RstGateSize;
      grav_q   <= RstGravity;
      hover_q  <= RstHover;
      var_q    <= RstInitVar;
      change_q <= 17'sd0;
      innov_q  <= 18'sd0;
      gated_q  <= 1'b0;
      init_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMinHover:   min_q    <= cfg_data_i[15:0];
          RegMaxHover:   max_q    <= cfg_data_i[15:0];
          RegInitHover:  init_h_q <= cfg_data_i[15:0];
          RegInitVar:    init_v_q <= cfg_data_i;
          RegProcNoise:  pn_q     <= cfg_data_i;
          RegAccelNoise: an_q     <= cfg_data_i;
          RegGateSize:   gate_q   <= cfg_data_i[11:0];
          RegGravity:    grav_q   <= cfg_data_i[14:0];
          default: begin end
        endcase
      end
      if (cmd_i.commit) begin
        if (req_q) begin
          hover_q  <= clamp_hover($signed({40'd0, init_h_q}), min_q, max_q);
          var_q    <= init_v_q;
          change_q <= 17'sd0;
          innov_q  <= 18'sd0;
          gated_q  <= 1'b0;
          init_q   <= 1'b0;
        end else if (dt_q != 16'd0) begin
          hover_q  <= h_new;
          var_q    <= p_q;
          change_q <= $signed({1'b0, h_new}) - $signed({1'b0, hover_q});
          innov_q  <= w_innov_q;
          gated_q  <= !pass_q;
          init_q   <= 1'b1;
        end
      end
    end
  end

  assign sts_o.restart   = req_q;
  assign sts_o.skip      = (dt_q == 16'd0);
  assign sts_o.do_update = upd;
  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;

  assign hover_estimate_o = hover_q;
  assign hover_change_o   = change_q;
  assign innovation_o     = innov_q;
  assign gated_o          = gated_q;
  assign initialized_o    = init_q;

endmodule

// File: rtl/hte_ctrl.sv
// ----------------------------------------------------------------------------
// hte_ctrl
// Sequencer: takes a sample, steps the datapath through the filter update
// and hands the result to the output channel.
// ----------------------------------------------------------------------------
module hte_ctrl
  import hte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  hte_sts_t sts_i,
  output hte_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StIssue  = 3'd2;
  localparam logic [2:0] StWait   = 3'd3;
  localparam logic [2:0] StCommit = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       ov_q, ov_d;
  logic       done;

  assign done = step_is_div(step_q) ? sts_i.div_done : sts_i.mul_done;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    ov_d         = ov_q && out_stall_i;
    cmd_o.load   = 1'b0;
    cmd_o.go     = 1'b0;
    cmd_o.commit = 1'b0;
    cmd_o.step   = step_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        if (sts_i.restart || sts_i.skip) begin
          state_d = StCommit;
        end else begin
          step_d  = StPn;
          state_d = StIssue;
        end
      end
      StIssue: begin
        // update steps run only when the gate test passed with S nonzero
        if (step_q == StXa && !sts_i.do_update) begin
          state_d = StCommit;
        end else begin
          cmd_o.go = 1'b1;
          state_d  = StWait;
        end
      end
      StWait: begin
        if (done) begin
          if (step_q == StPf) begin
            state_d = StCommit;
          end else begin
            step_d  = step_q + 4'd1;
            state_d = StIssue;
          end
        end
      end
      StCommit: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          ov_d         = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StPn;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ov_q;

endmodule
